// ----- rtl/fftc_pkg.sv -----
// Shared constants, coefficient table, helper functions and types of the FIR filter.
package fftc_pkg;

	localparam int TAPS         = 100;
	localparam int MAX_TAPS     = 100;
	localparam int SAMPLE_WIDTH = 32;
	localparam int DW           = 32;
	localparam int AW           = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int CFW          = 8;
	localparam int CIW          = $clog2(MAX_TAPS);
	localparam int SX_SHIFT     = DW - SAMPLE_WIDTH;

	localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

	// Fixed coefficients, position 0 weights the newest sample
	localparam logic signed [CFW-1:0] COEF_TABLE [MAX_TAPS] = '{
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6,
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6,
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6,
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd13, -8'sd2, 8'sd9, 8'sd11, 8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6, 8'sd74,
		8'sd26, 8'sd18, 8'sd95, -8'sd43, 8'sd6
	};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// One read issued towards the MAC pipeline
	typedef struct packed {
		logic          vld;
		logic          first;
		logic          last;
		logic [AW-1:0] tap;
	} tap_ctl_t;

	// Coefficient sign-extended to the data width
	function automatic logic [DW-1:0] coef_at(input logic [AW-1:0] tap);
		logic [CIW-1:0] idx;
		logic [CFW-1:0] c;
		idx = CIW'(tap);
		c   = COEF_TABLE[idx];
		return {{(DW-CFW){c[CFW-1]}}, c};
	endfunction

	// Keep the low SAMPLE_WIDTH bits and sign-extend them
	function automatic logic [DW-1:0] widen(input logic [DW-1:0] raw);
		logic [DW-1:0] t;
		t = raw << SX_SHIFT;
		return DW'($signed(t) >>> SX_SHIFT);
	endfunction

endpackage

// ----- rtl/fftc_if.sv -----
// Valid/ready stream interfaces for the sample and result channels.
interface fftc_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface fftc_filtered_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink   (input valid, input filtered, output ready);
endinterface

// ----- rtl/fftc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fftc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100,
	parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ABITS-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [ABITS-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/fftc_mac.sv -----
// Multiply-accumulate pipeline over the delay-line read stream.
module fftc_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fftc_pkg::tap_ctl_t        ctl,
	input  logic [fftc_pkg::DW-1:0]   rdata,
	input  logic                      res_taken,
	output logic                      res_vld,
	output logic [fftc_pkg::DW-1:0]   res
);
	import fftc_pkg::*;

	tap_ctl_t      ctl_s1;
	tap_ctl_t      ctl_s2;
	logic [DW-1:0] prod_s2;
	logic [DW-1:0] acc_q;
	logic          res_vld_q;

	// s1: flags line up with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	// s2: wrapped product, low word only
	always_ff @(posedge clk) begin
		prod_s2 <= rdata * coef_at(ctl_s1.tap);
	end

	// accumulate; the first tap restarts the sum
	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= ctl_s2.first ? prod_s2 : acc_q + prod_s2;
		end
	end

	// result pending until moved into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (ctl_s2.vld && ctl_s2.last) begin
			res_vld_q <= 1'b1;
		end else if (res_taken) begin
			res_vld_q <= 1'b0;
		end
	end

	assign res_vld = res_vld_q;
	assign res     = acc_q;

endmodule

// ----- rtl/fftc_ctrl.sv -----
// Sequencer: clearing pass, circular delay-line write and tap read sweep.
module fftc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [fftc_pkg::DW-1:0]   in_sample,
	output logic                      in_ready,
	input  logic                      res_vld,
	input  logic                      res_taken,
	output logic                      ram_we,
	output logic [fftc_pkg::AW-1:0]   ram_waddr,
	output logic [fftc_pkg::DW-1:0]   ram_wdata,
	output logic [fftc_pkg::AW-1:0]   ram_raddr,
	output fftc_pkg::tap_ctl_t        ctl
);
	import fftc_pkg::*;

	state_t        state_q, state_d;
	logic [AW-1:0] k_q, k_d;
	logic [AW-1:0] hd_q, hd_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] new_hd;

	// newest sample goes one place below the current head
	assign new_hd = (hd_q == '0) ? LAST_TAP : hd_q - AW'(1);

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			k_q     <= '0;
			hd_q    <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			hd_q    <= hd_d;
			ptr_q   <= ptr_d;
		end
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		hd_d      = hd_q;
		ptr_d     = ptr_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = '0;
		ram_raddr = ptr_q;
		ctl       = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (k_q == LAST_TAP) begin
					k_d     = '0;
					state_d = ST_IDLE;
				end else begin
					k_d = k_q + AW'(1);
				end
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_waddr = new_hd;
				ram_wdata = widen(in_sample);
				if (in_valid) begin
					ram_we  = 1'b1;
					hd_d    = new_hd;
					ptr_d   = new_hd;
					k_d     = '0;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.vld   = 1'b1;
				ctl.first = (k_q == '0);
				ctl.last  = (k_q == LAST_TAP);
				ctl.tap   = k_q;
				ptr_d     = (ptr_q == LAST_TAP) ? '0 : ptr_q + AW'(1);
				if (k_q == LAST_TAP) begin
					k_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + AW'(1);
				end
			end
			ST_DRAIN: begin
				if (res_vld && res_taken) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ----- rtl/fir_filter_fixed_taps_core.sv -----
// Top level of the 100-tap fixed-coefficient FIR filter.
// A taken sample is written into the delay-line RAM; its taps then pass the registered
// RAM read, product register and accumulator into the output register. The single
// shared multiply-accumulate sweeps the RAM one tap per cycle, and no new sample is
// taken until the result has entered the output register. Reset: asynchronous, active
// low; then a clearing pass zeroes the delay line, taking no sample until it ends.
module fir_filter_fixed_taps_core (
	input  logic                    clk,
	input  logic                    arst_n,
	fftc_sample_if.sink             sample_ch,
	fftc_filtered_if.source         filtered_ch
);
	import fftc_pkg::*;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;
	tap_ctl_t      ctl;
	logic          res_vld;
	logic [DW-1:0] res;
	logic          res_taken;
	logic          out_vld_q;
	logic [DW-1:0] filtered_q;

	fftc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_sample (DW'(sample_ch.sample)),
		.in_ready  (sample_ch.ready),
		.res_vld   (res_vld),
		.res_taken (res_taken),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ctl       (ctl)
	);

	fftc_ram #(
		.WIDTH (DW),
		.DEPTH (TAPS),
		.ABITS (AW)
	) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fftc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rdata     (ram_rdata),
		.res_taken (res_taken),
		.res_vld   (res_vld),
		.res       (res)
	);

	// output register: loads when empty or being emptied by a transfer
	assign res_taken = res_vld && (!out_vld_q || filtered_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_taken) begin
			out_vld_q <= 1'b1;
		end else if (filtered_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			filtered_q <= res;
		end
	end

	assign filtered_ch.valid    = out_vld_q;
	assign filtered_ch.filtered = $signed(filtered_q);

endmodule
